FILE: design/scse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scse_pkg: shared types and helpers for the cost shape evaluator
// Shape codes, the per-stage item record and saturating 64-bit helpers.
// ----------------------------------------------------------------------------
package scse_pkg;

	localparam int NSTG = 20;

	typedef logic signed [63:0] s64_t;

	localparam s64_t S64_MAX = {1'b0, {63{1'b1}}};
	localparam s64_t S64_MIN = {1'b1, {63{1'b0}}};

	localparam logic [4:0] M_CONST    = 5'd0;
	localparam logic [4:0] M_LIN_X    = 5'd1;
	localparam logic [4:0] M_LIN_Y    = 5'd2;
	localparam logic [4:0] M_LIN_Z    = 5'd3;
	localparam logic [4:0] M_ADD      = 5'd4;
	localparam logic [4:0] M_MUL      = 5'd5;
	localparam logic [4:0] M_MIN      = 5'd6;
	localparam logic [4:0] M_MAX      = 5'd7;
	localparam logic [4:0] M_SUB      = 5'd8;
	localparam logic [4:0] M_DIAG     = 5'd9;
	localparam logic [4:0] M_QUAD_X   = 5'd10;
	localparam logic [4:0] M_QUAD_Y   = 5'd11;
	localparam logic [4:0] M_QUAD_Z   = 5'd12;
	localparam logic [4:0] M_INTER    = 5'd13;
	localparam logic [4:0] M_LIN_YZ   = 5'd14;
	localparam logic [4:0] M_MAX_YZ   = 5'd15;
	localparam logic [4:0] M_LIT_Y    = 5'd16;
	localparam logic [4:0] M_EXPMOD   = 5'd17;
	localparam logic [4:0] M_ABOVE    = 5'd18;
	localparam logic [4:0] M_BELOW    = 5'd19;

	typedef struct packed {
		logic [4:0] mode;
		s64_t c0, c1, c2, c3, c4, c5, c6, c7;
		s64_t x, y, z;
		s64_t lop;
		s64_t v1, v2, v3, v4, v5;
		s64_t w1;
		s64_t acc;
		s64_t half;
		s64_t res;
	} item_t;

	function automatic s64_t sadd(input s64_t a, input s64_t b);
		s64_t s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	function automatic s64_t smax(input s64_t a, input s64_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic s64_t smin(input s64_t a, input s64_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic s64_t sneg(input s64_t a);
		return (a == S64_MIN) ? S64_MAX : -a;
	endfunction

endpackage
`default_nettype wire

FILE: design/scse_smul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scse_smul: four-stage saturating signed 64x64 multiplier
// Magnitudes, 32x32 partials, 128-bit combine, then clamp and sign.
// ----------------------------------------------------------------------------
module scse_smul (
	input  wire logic          clk,
	input  wire logic [3:0]    en,
	input  wire scse_pkg::s64_t a,
	input  wire scse_pkg::s64_t b,
	output      scse_pkg::s64_t p
);
	import scse_pkg::*;

	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  ma_s1, mb_s1;
	logic [63:0]  ll_s2, lh_s2, hl_s2, hh_s2;
	logic [127:0] m_s3;
	s64_t         p_s4;

	logic [63:0]  ma, mb, lim;
	logic         over;

	assign ma = a[63] ? 64'(-a) : 64'(a);
	assign mb = b[63] ? 64'(-b) : 64'(b);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s1 <= a[63] ^ b[63];
			ma_s1  <= ma;
			mb_s1  <= mb;
		end
		if (en[1]) begin
			neg_s2 <= neg_s1;
			ll_s2  <= ma_s1[31:0]  * mb_s1[31:0];
			lh_s2  <= ma_s1[31:0]  * mb_s1[63:32];
			hl_s2  <= ma_s1[63:32] * mb_s1[31:0];
			hh_s2  <= ma_s1[63:32] * mb_s1[63:32];
		end
		if (en[2]) begin
			neg_s3 <= neg_s2;
			m_s3   <= {64'd0, ll_s2} + {32'd0, lh_s2, 32'd0} + {32'd0, hl_s2, 32'd0}
				+ {hh_s2, 64'd0};
		end
		if (en[3])
			p_s4 <= over ? (neg_s3 ? S64_MIN : S64_MAX)
				: (neg_s3 ? -s64_t'(m_s3[63:0]) : s64_t'(m_s3[63:0]));
	end

	// a negative product may reach 2^63 in magnitude
	assign lim  = {1'b0, {63{1'b1}}} + {63'd0, neg_s3};
	assign over = (|m_s3[127:64]) || (m_s3[63:0] > lim);

	assign p = p_s4;

endmodule
`default_nettype wire

FILE: design/saturating_cost_shape_evaluator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// saturating_cost_shape_evaluator_core: pipelined cost shape evaluator
// Evaluates one of twenty saturating cost shapes per beat.
//
// Input channel in_valid/in_ready carries mode, eight coefficients and the
// sizes size_x, size_y, size_z. Output channel out_valid/out_ready carries
// one cost per input beat, in order.
// Throughput is one beat per cycle while out_ready does not stall the
// output, over twenty stages: an input register that also forms the
// linear operand, three saturating multiplier layers of four stages each
// (size products, coefficient products, the cubic term of the exponent-mod
// shape), then a five-stage saturating add chain and two stages of final
// selection and halving.
// Every stage has its own valid bit; a stage moves when it is empty or the
// stage after it moves, so bubbles are squeezed out and the input keeps
// being taken while a result waits at the output.
// When out_ready is low the output beat holds; once every stage is full,
// in_ready drops. Nothing is lost or repeated.
// Reset clears the valid bits only; data registers are not reset.
// Codes 20 to 31 give the maximum cost.
// ----------------------------------------------------------------------------
module saturating_cost_shape_evaluator_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire logic [4:0]     mode,
	input  wire scse_pkg::s64_t coef_0,
	input  wire scse_pkg::s64_t coef_1,
	input  wire scse_pkg::s64_t coef_2,
	input  wire scse_pkg::s64_t coef_3,
	input  wire scse_pkg::s64_t coef_4,
	input  wire scse_pkg::s64_t coef_5,
	input  wire scse_pkg::s64_t coef_6,
	input  wire scse_pkg::s64_t coef_7,
	input  wire scse_pkg::s64_t size_x,
	input  wire scse_pkg::s64_t size_y,
	input  wire scse_pkg::s64_t size_z,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      scse_pkg::s64_t cost
);
	import scse_pkg::*;

	item_t        item_s [1:NSTG];
	item_t        nxt    [1:NSTG];
	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] en;

	// multiplier operands and results
	s64_t u1a, u1b, u2v, p1, p2, p3;
	s64_t v1a, v1b, v2a, v2b, v3a, v3b, r1, r2, r3, r4, r5;
	s64_t w1;
	s64_t base, t1, t2, t3, t4, t5;

	// ---- stall chain: a stage moves when empty or when its successor moves
	always_comb begin
		en[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign in_ready  = en[1];
	assign out_valid = vld_s[NSTG];
	assign cost      = item_s[NSTG].res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1])
				vld_s[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++)
				if (en[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NSTG; k++)
			if (en[k])
				item_s[k] <= nxt[k];
	end

	// ---- layer 1: size products (x*y or y*z, v*v, y*y)
	always_comb begin
		u1a = (item_s[1].mode == M_EXPMOD) ? item_s[1].y : item_s[1].x;
		u1b = (item_s[1].mode == M_EXPMOD) ? item_s[1].z : item_s[1].y;
		unique case (item_s[1].mode)
			M_QUAD_Y: u2v = item_s[1].y;
			M_QUAD_Z: u2v = item_s[1].z;
			default:  u2v = item_s[1].x;
		endcase
	end

	scse_smul u_mul_p1 (.clk, .en(en[5:2]), .a(u1a), .b(u1b), .p(p1));
	scse_smul u_mul_p2 (.clk, .en(en[5:2]), .a(u2v), .b(u2v), .p(p2));
	scse_smul u_mul_p3 (.clk, .en(en[5:2]), .a(item_s[1].y), .b(item_s[1].y), .p(p3));

	// ---- layer 2: coefficient products
	always_comb begin
		item_t it;
		it = item_s[5];
		v1a = (it.mode == M_ABOVE || it.mode == M_BELOW) ? it.c3 : it.c1;
		v1b = (it.mode == M_MUL || it.mode == M_EXPMOD) ? p1 : it.lop;
		v2a = (it.mode == M_ABOVE || it.mode == M_BELOW) ? it.c4 : it.c2;
		unique case (it.mode)
			M_QUAD_X, M_QUAD_Y, M_QUAD_Z: v2b = p2;
			M_LIN_YZ: v2b = it.z;
			default:  v2b = it.y;
		endcase
		unique case (it.mode)
			M_EXPMOD: begin
				v3a = p1;
				v3b = it.z;
			end
			M_ABOVE, M_BELOW: begin
				v3a = it.c5;
				v3b = p2;
			end
			default: begin
				v3a = it.c3;
				v3b = p1;
			end
		endcase
	end

	scse_smul u_mul_v1 (.clk, .en(en[9:6]), .a(v1a), .b(v1b), .p(r1));
	scse_smul u_mul_v2 (.clk, .en(en[9:6]), .a(v2a), .b(v2b), .p(r2));
	scse_smul u_mul_v3 (.clk, .en(en[9:6]), .a(v3a), .b(v3b), .p(r3));
	scse_smul u_mul_v4 (.clk, .en(en[9:6]), .a(item_s[5].c6), .b(p1), .p(r4));
	scse_smul u_mul_v5 (.clk, .en(en[9:6]), .a(item_s[5].c7), .b(p3), .p(r5));

	// ---- layer 3: c2 * (y*z)*z for the exponent-mod shape
	scse_smul u_mul_w1 (.clk, .en(en[13:10]), .a(item_s[9].c2), .b(r3), .p(w1));

	// ---- add chain terms; unused terms are zero
	always_comb begin
		item_t a, b;
		a = item_s[13];
		b = item_s[14];
		unique case (a.mode)
			M_EXPMOD: begin
				base = a.v1;
				t1   = w1;
			end
			M_ABOVE, M_BELOW: begin
				base = a.c2;
				t1   = a.v1;
			end
			default: begin
				base = a.c0;
				t1   = a.v1;
			end
		endcase
		unique case (b.mode)
			M_EXPMOD: t2 = b.c0;
			M_QUAD_X, M_QUAD_Y, M_QUAD_Z, M_INTER, M_LIN_YZ, M_ABOVE, M_BELOW:
				t2 = b.v2;
			default: t2 = '0;
		endcase
		t3 = (item_s[15].mode == M_INTER || item_s[15].mode == M_ABOVE
			|| item_s[15].mode == M_BELOW) ? item_s[15].v3 : '0;
		t4 = (item_s[16].mode == M_ABOVE || item_s[16].mode == M_BELOW)
			? item_s[16].v4 : '0;
		t5 = (item_s[17].mode == M_ABOVE || item_s[17].mode == M_BELOW)
			? item_s[17].v5 : '0;
	end

	// ---- next-stage records
	always_comb begin
		item_t f;
		f = item_s[18];

		nxt[1]      = item_s[1];
		nxt[1].mode = mode;
		nxt[1].c0   = coef_0;
		nxt[1].c1   = coef_1;
		nxt[1].c2   = coef_2;
		nxt[1].c3   = coef_3;
		nxt[1].c4   = coef_4;
		nxt[1].c5   = coef_5;
		nxt[1].c6   = coef_6;
		nxt[1].c7   = coef_7;
		nxt[1].x    = size_x;
		nxt[1].y    = size_y;
		nxt[1].z    = size_z;
		unique case (mode)
			M_LIN_Y, M_QUAD_Y, M_LIN_YZ:  nxt[1].lop = size_y;
			M_LIN_Z, M_QUAD_Z, M_LIT_Y:   nxt[1].lop = size_z;
			M_ADD:    nxt[1].lop = sadd(size_x, size_y);
			M_MIN:    nxt[1].lop = smin(size_x, size_y);
			M_MAX:    nxt[1].lop = smax(size_x, size_y);
			M_SUB:    nxt[1].lop = sadd(size_x, sneg(size_y));
			M_MAX_YZ: nxt[1].lop = smax(size_y, size_z);
			default:  nxt[1].lop = size_x;
		endcase

		for (int k = 2; k <= NSTG; k++)
			nxt[k] = item_s[k-1];

		nxt[10].v1 = r1;
		nxt[10].v2 = r2;
		nxt[10].v3 = r3;
		nxt[10].v4 = r4;
		nxt[10].v5 = r5;
		nxt[14].w1 = w1;

		nxt[14].acc = sadd(base, t1);
		nxt[15].acc = sadd(item_s[14].acc, t2);
		nxt[16].acc = sadd(item_s[15].acc, t3);
		nxt[17].acc = sadd(item_s[16].acc, t4);
		nxt[18].acc = sadd(item_s[17].acc, t5);

		// halving rounds toward zero
		nxt[19].half = (f.acc + s64_t'({63'd0, f.acc[63]})) >>> 1;
		unique case (f.mode)
			M_CONST: nxt[19].res = f.c0;
			M_LIN_X, M_LIN_Y, M_LIN_Z, M_ADD, M_MUL, M_MIN, M_MAX,
			M_QUAD_X, M_QUAD_Y, M_QUAD_Z, M_INTER, M_LIN_YZ, M_MAX_YZ, M_EXPMOD:
				nxt[19].res = f.acc;
			M_SUB:   nxt[19].res = smax(f.c2, f.acc);
			M_DIAG:  nxt[19].res = (f.x == f.y) ? f.acc : f.c2;
			M_LIT_Y: nxt[19].res = smax(f.y, f.acc);
			M_ABOVE: nxt[19].res = (f.x < f.y) ? f.c0 : smax(f.c1, f.acc);
			M_BELOW: nxt[19].res = (f.x > f.y) ? f.c0 : smax(f.c1, f.acc);
			default: nxt[19].res = S64_MAX;
		endcase

		// 1.5x scale of the exponent-mod shape when x > z
		if (item_s[19].mode == M_EXPMOD && item_s[19].x > item_s[19].z)
			nxt[20].res = sadd(item_s[19].acc, item_s[19].half);
	end

endmodule
`default_nettype wire
